FILE: hw/rtl/auto_peak_spectrum_bar_display_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef AUTO_PEAK_SPECTRUM_BAR_DISPLAY_MACROS_SVH
`define AUTO_PEAK_SPECTRUM_BAR_DISPLAY_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define APSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define APSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define APSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define APSB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/apsb_pkg.sv
package apsb_pkg;

	localparam int MATRIX_SIDE = 8;
	localparam int BANDS       = 7;
	localparam int DIV_STEPS   = 3;

	localparam logic [9:0] SENS_MAX    = 10'd630;
	localparam logic [9:0] LEVEL_FLOOR = 10'd30;
	localparam logic [7:0] HUE_SEG1    = 8'd85;
	localparam logic [7:0] HUE_SEG2    = 8'd170;
	localparam logic [7:0] FULL_SCALE  = 8'd255;
	localparam logic [5:0] PIX_LAST    = 6'd63;
	localparam logic [3:0] HEIGHT_MAX  = 4'd8;

	// Configuration register indexes
	localparam logic [0:0] REG_SENSITIVITY = 1'b0;
	localparam logic [0:0] REG_ORIENTATION = 1'b1;

	typedef logic [9:0] level_t;
	typedef logic [3:0] height_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Per-frame settings handed to the pixel emitter
	typedef struct packed {
		logic       start;
		logic       orient;
		logic [7:0] hue;
	} frame_ctl_t;

	// Color wheel: three linear ramps over 0..255
	function automatic rgb_t hue_to_rgb(input logic [7:0] pos);
		rgb_t       c;
		logic [7:0] p;
		logic [7:0] p3;
		if (pos < HUE_SEG1) begin
			p = pos;
		end else if (pos < HUE_SEG2) begin
			p = pos - HUE_SEG1;
		end else begin
			p = pos - HUE_SEG2;
		end
		p3 = 8'({1'b0, p, 1'b0} + {2'b00, p});
		if (pos < HUE_SEG1) begin
			c.red   = p3;
			c.green = FULL_SCALE - p3;
			c.blue  = 8'd0;
		end else if (pos < HUE_SEG2) begin
			c.red   = FULL_SCALE - p3;
			c.green = 8'd0;
			c.blue  = p3;
		end else begin
			c.red   = 8'd0;
			c.green = p3;
			c.blue  = FULL_SCALE - p3;
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/apsb_lane.sv
module apsb_lane
	import apsb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    step,
	input  level_t  level,
	input  level_t  peak,
	output height_t height
);

	logic [9:0]  rem_q;
	logic [9:0]  den_q;
	logic [2:0]  quo_q;
	logic        zero_q;
	logic        sat_q;
	logic [10:0] rem2;
	logic        ge;

	// One restoring division step: quotient bit of 8*(level-30)/(peak-30)
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b1;
			sat_q  <= 1'b0;
		end else if (start) begin
			zero_q <= (peak <= LEVEL_FLOOR) || (level <= LEVEL_FLOOR);
			sat_q  <= level >= peak;
		end
	end

	// Load operands, then shift in one quotient bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= level - LEVEL_FLOOR;
			den_q <= peak - LEVEL_FLOOR;
			quo_q <= 3'd0;
		end else if (step) begin
			rem_q <= ge ? 10'(rem2 - {1'b0, den_q}) : rem2[9:0];
			quo_q <= {quo_q[1:0], ge};
		end
	end

	assign height = zero_q ? 4'd0 : (sat_q ? HEIGHT_MAX : {1'b0, quo_q});

endmodule

FILE: hw/rtl/apsb_emit.sv
`include "auto_peak_spectrum_bar_display_macros.svh"

module apsb_emit
	import apsb_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  frame_ctl_t                      ctl,
	input  logic [BANDS-1:0][3:0]           heights,
	output logic                            busy,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [5:0]                      pixel_index,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic                            frame_end
);

	logic                          run_q;
	logic [5:0]                    pix_q;
	logic                          valid_q;
	logic [7:0]                    hue_q;
	logic                          orient_q;
	logic                          load;
	logic [2:0]                    row;
	logic [2:0]                    col;
	logic [MATRIX_SIDE-1:0][3:0]   hpad;
	logic                          on;
	rgb_t                          wheel;

	// Row 7 has no band: pad with a zero height
	assign hpad  = {4'd0, heights};
	assign row   = pix_q[5:3];
	assign col   = pix_q[2:0];
	assign on    = {1'b0, col} < hpad[row];
	assign wheel = hue_to_rgb(8'(pix_q) + hue_q);
	assign load  = run_q && (!valid_q || !out_stall);

	// Frame sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			pix_q   <= 6'd0;
			valid_q <= 1'b0;
		end else begin
			if (ctl.start) begin
				run_q <= 1'b1;
				pix_q <= 6'd0;
			end else if (load) begin
				pix_q <= pix_q + 6'd1;
				if (pix_q == PIX_LAST) begin
					run_q <= 1'b0;
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Hold frame settings
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			hue_q    <= ctl.hue;
			orient_q <= ctl.orient;
		end
	end

	// Output register: refill on transfer or when empty
	always_ff @(posedge clk) begin
		if (load) begin
			pixel_index <= orient_q ? {col, ~row} : {row, col};
			red         <= on ? wheel.red   : 8'd0;
			green       <= on ? wheel.green : 8'd0;
			blue        <= on ? wheel.blue  : 8'd0;
			frame_end   <= pix_q == PIX_LAST;
		end
	end

	assign busy      = run_q;
	assign out_valid = valid_q;

	`APSB_ASSERT_IMP(a_start_idle, clk, arst_n, ctl.start, !run_q, "frame start while emitting")
	`APSB_ASSERT_NXT(a_load_valid, clk, arst_n, load, valid_q, "loaded pixel not presented")

endmodule

FILE: hw/rtl/auto_peak_spectrum_bar_display.sv
// An accepted frame goes through the peak update, the divider load, 3 division
// steps in the band lanes, then 64 pixels at one per cycle, slowed by out_stall,
// and then back to idle. A new frame is taken only once the previous one is done:
// after its last pixel is in the output register, the emitter drops busy and the
// sequencer returns to idle.
// Reset (arst_n, async): sensitivity 630, orientation 0, peak 630, all bars 0, no output.
`include "auto_peak_spectrum_bar_display_macros.svh"

module auto_peak_spectrum_bar_display
	import apsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [9:0] band0_level,
	input  logic [9:0] band1_level,
	input  logic [9:0] band2_level,
	input  logic [9:0] band3_level,
	input  logic [9:0] band4_level,
	input  logic [9:0] band5_level,
	input  logic [9:0] band6_level,
	input  logic [7:0] hue_offset,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] pixel_index,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       frame_end
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PEAK = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [1:0]              div_cnt_q;
	level_t                  sens_q;
	logic                    orient_q;
	level_t                  peak_q;
	level_t [BANDS-1:0]      lvl_q;
	logic [7:0]              hue_q;
	level_t                  sens_sat;
	level_t                  frame_max;
	level_t                  peak_next;
	logic                    accept;
	logic                    last_step;
	logic                    emit_busy;
	logic [BANDS-1:0][3:0]   heights;
	frame_ctl_t              ctl;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign last_step = (state_q == ST_DIV) && (div_cnt_q == 2'(DIV_STEPS - 1));
	assign sens_sat  = (sens_q > SENS_MAX) ? SENS_MAX : sens_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q   <= SENS_MAX;
			orient_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSITIVITY: sens_q   <= cfg_data;
				REG_ORIENTATION: orient_q <= cfg_data[0];
				default:         sens_q   <= sens_q;
			endcase
		end
	end

	// Capture the frame
	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_q <= {band6_level, band5_level, band4_level, band3_level,
				band2_level, band1_level, band0_level};
			hue_q <= hue_offset;
		end
	end

	// Peak: rise to the frame maximum, then decay by one, snap up to the floor or hold
	always_comb begin
		frame_max = peak_q;
		for (int i = 0; i < BANDS; i++) begin
			if (lvl_q[i] > frame_max) begin
				frame_max = lvl_q[i];
			end
		end
		if (frame_max >= sens_sat) begin
			peak_next = (frame_max != 10'd0) ? frame_max - 10'd1 : frame_max;
		end else if (sens_sat == SENS_MAX) begin
			peak_next = SENS_MAX;
		end else begin
			peak_next = frame_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= SENS_MAX;
		end else if (state_q == ST_PEAK) begin
			peak_q <= peak_next;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_PEAK;
				end
				ST_PEAK: state_q <= ST_LOAD;
				ST_LOAD: begin
					state_q   <= ST_DIV;
					div_cnt_q <= 2'd0;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 2'd1;
					if (last_step) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: if (!emit_busy) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// One divider lane per band
	for (genvar b = 0; b < BANDS; b++) begin : g_lane
		apsb_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (state_q == ST_LOAD),
			.step   (state_q == ST_DIV),
			.level  (lvl_q[b]),
			.peak   (peak_q),
			.height (heights[b])
		);
	end

	// Merge the bar heights into the pixel stream
	assign ctl.start  = last_step;
	assign ctl.orient = orient_q;
	assign ctl.hue    = hue_q;

	apsb_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.heights     (heights),
		.busy        (emit_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end)
	);

	`APSB_ASSERT_IMP(a_busy_emit, clk, arst_n, emit_busy, state_q == ST_EMIT, "emitter runs outside emit phase")
	`APSB_ASSERT_IMP(a_peak_floor, clk, arst_n, (state_q == ST_LOAD) && (sens_sat == SENS_MAX), peak_q >= SENS_MAX - 10'd1, "peak below floor")
	`APSB_ASSERT_NXT(a_accept_peak, clk, arst_n, accept, state_q == ST_PEAK, "accepted frame skipped peak update")

endmodule

FILE: verif/auto_peak_spectrum_bar_display_tb.sv
`timescale 1ns / 100ps

module auto_peak_spectrum_bar_display_tb;
	import apsb_pkg::*;

	typedef struct packed {
		level_t [BANDS-1:0] lvl;
		logic [7:0]         hue;
	} frame_t;

	typedef struct packed {
		logic [5:0] idx;
		rgb_t       color;
		logic       last;
	} pixel_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_SENSITIVITY;
	logic [9:0] cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [9:0] band0_level = '0;
	logic [9:0] band1_level = '0;
	logic [9:0] band2_level = '0;
	logic [9:0] band3_level = '0;
	logic [9:0] band4_level = '0;
	logic [9:0] band5_level = '0;
	logic [9:0] band6_level = '0;
	logic [7:0] hue_offset = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [5:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       frame_end;

	auto_peak_spectrum_bar_display dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.band0_level(band0_level),
		.band1_level(band1_level),
		.band2_level(band2_level),
		.band3_level(band3_level),
		.band4_level(band4_level),
		.band5_level(band5_level),
		.band6_level(band6_level),
		.hue_offset (hue_offset),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_index(pixel_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_end  (frame_end)
	);

	// Predictor state and register copies
	level_t     peak_lvl = SENS_MAX;
	logic [9:0] sens_reg = SENS_MAX;
	logic       orient_reg = 1'b0;

	frame_t pending_frames[$];
	pixel_t expected_pixels[$];
	int     frames_queued = 0;
	int     frames_taken = 0;
	int     pixel_errors = 0;
	bit     quiet = 1'b0;
	bit     in_fire = 1'b0;
	int     in_gap = 0;
	int     stall_left = 0;
	int     stall_len;
	frame_t drive_fr;
	frame_t seen_fr;
	pixel_t got_px;
	pixel_t want_px;

	initial begin
		forever #6 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 15);
		if (quiet || r < 8)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic int pick_level();
		int p;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1023;
			2: return $urandom_range(25, 35);
			3: begin
				p = int'(peak_lvl) + $urandom_range(0, 6) - 3;
				return (p < 0) ? 0 : (p > 1023 ? 1023 : p);
			end
			default: return $urandom_range(0, 1023);
		endcase
	endfunction

	// Three linear ramps around the color wheel
	function automatic rgb_t wheel(input logic [7:0] pos);
		int   ramp;
		rgb_t c;
		if (pos < HUE_SEG1) begin
			ramp = int'(pos) * 3;
			c = {8'(ramp), 8'(255 - ramp), 8'd0};
		end else if (pos < HUE_SEG2) begin
			ramp = (int'(pos) - int'(HUE_SEG1)) * 3;
			c = {8'(255 - ramp), 8'd0, 8'(ramp)};
		end else begin
			ramp = (int'(pos) - int'(HUE_SEG2)) * 3;
			c = {8'd0, 8'(ramp), 8'(255 - ramp)};
		end
		return c;
	endfunction

	// Update the peak, size the bars and queue all 64 pixels of the frame
	function automatic void paint_frame(input frame_t fr);
		int     ceiling;
		int     h;
		int     hgt[BANDS];
		pixel_t px;
		ceiling = (sens_reg > SENS_MAX) ? int'(SENS_MAX) : int'(sens_reg);
		for (int b = 0; b < BANDS; b++)
			if (fr.lvl[b] > peak_lvl)
				peak_lvl = fr.lvl[b];
		if (int'(peak_lvl) >= ceiling) begin
			if (peak_lvl != 0)
				peak_lvl = peak_lvl - 1'b1;
		end else if (ceiling == int'(SENS_MAX)) begin
			peak_lvl = SENS_MAX;
		end
		for (int b = 0; b < BANDS; b++) begin
			if (peak_lvl <= LEVEL_FLOOR || fr.lvl[b] <= LEVEL_FLOOR) begin
				hgt[b] = 0;
			end else begin
				h = (int'(fr.lvl[b]) - int'(LEVEL_FLOOR)) * 8
					/ (int'(peak_lvl) - int'(LEVEL_FLOOR));
				hgt[b] = (h > int'(HEIGHT_MAX)) ? int'(HEIGHT_MAX) : h;
			end
		end
		for (int r = 0; r < MATRIX_SIDE; r++) begin
			for (int c = 0; c < MATRIX_SIDE; c++) begin
				px.idx = orient_reg ? 6'(c * MATRIX_SIDE + MATRIX_SIDE - 1 - r)
					: 6'(r * MATRIX_SIDE + c);
				if (r < BANDS && c < hgt[r])
					px.color = wheel(8'(r * MATRIX_SIDE + c + int'(fr.hue)));
				else
					px.color = '0;
				px.last = (r == MATRIX_SIDE - 1) && (c == MATRIX_SIDE - 1);
				expected_pixels.push_back(px);
			end
		end
	endfunction

	// Drive input transfers; hold the payload while stalled
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_frames.size() != 0) begin
				drive_fr = pending_frames.pop_front();
				band0_level <= drive_fr.lvl[0];
				band1_level <= drive_fr.lvl[1];
				band2_level <= drive_fr.lvl[2];
				band3_level <= drive_fr.lvl[3];
				band4_level <= drive_fr.lvl[4];
				band5_level <= drive_fr.lvl[5];
				band6_level <= drive_fr.lvl[6];
				hue_offset <= drive_fr.hue;
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the pixel stream at random
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			stall_len = pick_gap();
			out_stall <= (stall_len != 0);
			stall_left <= (stall_len != 0) ? stall_len - 1 : 0;
		end
	end

	// Predict on each input transfer, check each pixel transfer
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			seen_fr.lvl[0] = band0_level;
			seen_fr.lvl[1] = band1_level;
			seen_fr.lvl[2] = band2_level;
			seen_fr.lvl[3] = band3_level;
			seen_fr.lvl[4] = band4_level;
			seen_fr.lvl[5] = band5_level;
			seen_fr.lvl[6] = band6_level;
			seen_fr.hue = hue_offset;
			paint_frame(seen_fr);
			frames_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			got_px = {pixel_index, red, green, blue, frame_end};
			if (expected_pixels.size() == 0) begin
				pixel_errors++;
				if (pixel_errors <= 10)
					$display("unexpected pixel: idx %0d rgb %h last %b",
						got_px.idx, got_px.color, got_px.last);
			end else begin
				want_px = expected_pixels.pop_front();
				if (got_px.idx !== want_px.idx || got_px.color.red !== want_px.color.red
						|| got_px.color.green !== want_px.color.green
						|| got_px.color.blue !== want_px.color.blue
						|| got_px.last !== want_px.last) begin
					pixel_errors++;
					if (pixel_errors <= 10)
						$display("pixel mismatch: exp idx %0d rgb %h last %b, got idx %0d rgb %h last %b",
							want_px.idx, want_px.color, want_px.last,
							got_px.idx, got_px.color, got_px.last);
				end
			end
		end
	end

	task automatic send(input int l0, l1, l2, l3, l4, l5, l6, input int hue);
		frame_t fr;
		fr.lvl = {level_t'(l6), level_t'(l5), level_t'(l4), level_t'(l3),
			level_t'(l2), level_t'(l1), level_t'(l0)};
		fr.hue = 8'(hue);
		while (pending_frames.size() >= 2)
			@(posedge clk);
		pending_frames.push_back(fr);
		frames_queued++;
	endtask

	task automatic send_random();
		send(pick_level(), pick_level(), pick_level(), pick_level(), pick_level(),
			pick_level(), pick_level(), $urandom_range(0, 255));
	endtask

	// Wait until every frame is taken and every pixel seen, then let the pipe settle
	task automatic drain();
		while (frames_taken != frames_queued || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SENSITIVITY)
			sens_reg = val;
		else
			orient_reg = val[0];
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset settings: dark frame, full scale, levels around the floor, wheel seams
		send(0, 0, 0, 0, 0, 0, 0, 0);
		send(1023, 1023, 1023, 1023, 1023, 1023, 1023, 255);
		send(30, 31, 29, 0, 1023, 600, 631, 84);
		send(1022, 1021, 500, 250, 125, 62, 31, 85);
		send(341, 682, 341, 682, 341, 682, 341, 169);
		send(682, 341, 682, 341, 682, 341, 682, 170);
		send(40, 38, 35, 33, 32, 31, 30, 1);
		send(900, 800, 700, 600, 500, 400, 300, 128);
		send(5, 10, 15, 20, 25, 28, 29, 254);
		send(1023, 0, 1023, 0, 1023, 0, 1023, 42);
		drain();

		// Saturated sensitivity, horizontal layout
		write_reg(REG_SENSITIVITY, 10'd1023);
		write_reg(REG_ORIENTATION, 1'b1);
		send(0, 0, 0, 0, 0, 0, 0, 0);
		send(1023, 512, 256, 128, 64, 32, 16, 200);
		send(600, 610, 620, 630, 640, 650, 660, 100);
		send(31, 32, 33, 34, 35, 36, 37, 7);
		drain();

		// Zero sensitivity: quiet frames, the peak decays by one each frame
		write_reg(REG_SENSITIVITY, 10'd0);
		write_reg(REG_ORIENTATION, 1'b0);
		quiet = 1'b1;
		repeat (3) send(0, 0, 0, 0, 0, 0, 0, $urandom_range(0, 255));
		quiet = 1'b0;
		// Low levels near the floor
		repeat (20)
			send($urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
				$urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40),
				$urandom_range(0, 40), $urandom_range(0, 255));
		drain();

		// Random frames over a spread of settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_SENSITIVITY, SENS_MAX);
					write_reg(REG_ORIENTATION, 1'b1);
				end
				1: begin
					write_reg(REG_SENSITIVITY, 10'd31);
					write_reg(REG_ORIENTATION, 1'b0);
				end
				2: begin
					write_reg(REG_SENSITIVITY, 10'd0);
					write_reg(REG_ORIENTATION, 1'b1);
				end
				3: begin
					write_reg(REG_SENSITIVITY, 10'd629);
					write_reg(REG_ORIENTATION, 1'b0);
				end
				default: begin
					write_reg(REG_SENSITIVITY, 10'($urandom_range(0, 1023)));
					write_reg(REG_ORIENTATION, 1'($urandom_range(0, 1)));
				end
			endcase
			quiet = (ph == 3);
			repeat (18) send_random();
			drain();
		end
		quiet = 1'b0;

		repeat (20) @(posedge clk);
		if (pixel_errors == 0 && expected_pixels.size() == 0)
			$display("** auto_peak_spectrum_bar_display: PASSED **");
		else
			$display("** auto_peak_spectrum_bar_display: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#25ms;
		$display("** auto_peak_spectrum_bar_display: FAILED **");
		$finish;
	end

endmodule
